FILE: rtl/core/mfac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfac_pkg
// Types and codes shared by the message freshness and arm check block.
// ----------------------------------------------------------------------------
package mfac_pkg;

  localparam int CFG_BITS    = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int KIND_BITS   = 3;
  localparam int REASON_BITS = 3;
  localparam int MASK_BITS   = 6;
  localparam int NUM_TIMED   = 5;

  // operations
  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_LOCATION_MAX_AGE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OTHER_MAX_AGE      = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SYSTEM_VALID_AGE   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOCATION_VALID_AGE = 2'd3;

  localparam logic [CFG_BITS-1:0] LOCATION_MAX_AGE_RESET   = 32'd3000;
  localparam logic [CFG_BITS-1:0] OTHER_MAX_AGE_RESET      = 32'd22000;
  localparam logic [CFG_BITS-1:0] SYSTEM_VALID_AGE_RESET   = 32'd15000;
  localparam logic [CFG_BITS-1:0] LOCATION_VALID_AGE_RESET = 32'd2000;

  // message kinds
  localparam logic [KIND_BITS-1:0] KIND_LOCATION = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_BASIC    = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_AUTH     = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_SELF     = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_SYSTEM   = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_OPERATOR = 3'd5;

  // received mask bits
  localparam int MB_LOCATION = 0;
  localparam int MB_BASIC    = 1;
  localparam int MB_AUTH     = 2;
  localparam int MB_SELF     = 3;
  localparam int MB_SYSTEM   = 4;
  localparam int MB_OPERATOR = 5;
  localparam logic [MASK_BITS-1:0] MASK_REQUIRED = 6'h3B;

  // slots of the receive time store
  localparam int T_LOC   = 0;
  localparam int T_BASIC = 1;
  localparam int T_SELF  = 2;
  localparam int T_SYS   = 3;
  localparam int T_OPER  = 4;

  // failure reasons
  localparam logic [REASON_BITS-1:0] RSN_NONE         = 3'd0;
  localparam logic [REASON_BITS-1:0] RSN_NO_LOCATION  = 3'd1;
  localparam logic [REASON_BITS-1:0] RSN_NO_BASIC     = 3'd2;
  localparam logic [REASON_BITS-1:0] RSN_NO_SELF      = 3'd3;
  localparam logic [REASON_BITS-1:0] RSN_NO_OPERATOR  = 3'd4;
  localparam logic [REASON_BITS-1:0] RSN_NO_SYSTEM    = 3'd5;
  localparam logic [REASON_BITS-1:0] RSN_BAD_LOCATION = 3'd6;
  localparam logic [REASON_BITS-1:0] RSN_BAD_OPERATOR = 3'd7;

  typedef struct packed {
    logic               op;
    logic [31:0]        now_ms;
    logic [KIND_BITS-1:0] msg_kind;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
  } item_t;

  typedef struct packed {
    logic                   good_to_arm;
    logic [REASON_BITS-1:0] fail_reason;
    logic                   initialised;
    logic                   system_ok;
    logic                   location_ok;
  } result_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] location_max_age;
    logic [CFG_BITS-1:0] other_max_age;
    logic [CFG_BITS-1:0] system_valid_age;
    logic [CFG_BITS-1:0] location_valid_age;
  } cfg_t;

endpackage

FILE: rtl/core/mfac_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfac_in_if
// Input channel: one arrival or query transaction per handshake.
// ----------------------------------------------------------------------------
interface mfac_in_if;
  import mfac_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [31:0]          now_ms;
  logic [KIND_BITS-1:0] msg_kind;
  logic signed [31:0]   latitude;
  logic signed [31:0]   longitude;

  modport source (output valid, op, now_ms, msg_kind, latitude, longitude, input ready);
  modport sink   (input valid, op, now_ms, msg_kind, latitude, longitude, output ready);
endinterface

FILE: rtl/core/mfac_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfac_out_if
// Result channel: one verdict transaction per handshake.
// ----------------------------------------------------------------------------
interface mfac_out_if;
  import mfac_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   good_to_arm;
  logic [REASON_BITS-1:0] fail_reason;
  logic                   initialised;
  logic                   system_ok;
  logic                   location_ok;

  modport source (output valid, good_to_arm, fail_reason, initialised, system_ok,
                  location_ok, input ready);
  modport sink   (input valid, good_to_arm, fail_reason, initialised, system_ok,
                  location_ok, output ready);
endinterface

FILE: rtl/core/mfac_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfac_eval
// Applies one transaction to the tracking state and evaluates the verdict
// against the updated state.
// ----------------------------------------------------------------------------
module mfac_eval
  import mfac_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  item_t                                item,
  input  cfg_t                                 cfg,
  input  logic [NUM_TIMED-1:0][TIME_BITS-1:0]  times,
  input  logic [MASK_BITS-1:0]                 mask,
  input  logic                                 veh_zero,
  input  logic                                 opr_zero,
  output logic [NUM_TIMED-1:0][TIME_BITS-1:0]  times_next,
  output logic [MASK_BITS-1:0]                 mask_next,
  output logic                                 veh_zero_next,
  output logic                                 opr_zero_next,
  output result_t                              result
);

  localparam int W = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  logic [W-1:0]         now_w;
  logic [TIME_BITS-1:0] now_t;
  logic                 pos_zero;
  logic                 arrival;
  logic [NUM_TIMED-1:0] stale_loc;
  logic [NUM_TIMED-1:0] stale_oth;
  logic [NUM_TIMED-1:0] fresh_sys;
  logic [NUM_TIMED-1:0] fresh_loc;
  logic [TIME_BITS-1:0] age [NUM_TIMED];

  assign now_w    = W'(item.now_ms);
  assign now_t    = now_w[TIME_BITS-1:0];
  assign pos_zero = (item.latitude == 32'sd0) && (item.longitude == 32'sd0);
  assign arrival  = (item.op == OP_ARRIVAL);

  always_comb begin
    times_next    = times;
    mask_next     = mask;
    veh_zero_next = veh_zero;
    opr_zero_next = opr_zero;
    if (arrival) begin
      unique case (item.msg_kind)
        KIND_LOCATION: begin
          mask_next[MB_LOCATION] = 1'b1;
          times_next[T_LOC]      = now_t;
          veh_zero_next          = pos_zero;
        end
        KIND_BASIC: begin
          mask_next[MB_BASIC] = 1'b1;
          times_next[T_BASIC] = now_t;
        end
        KIND_AUTH: begin
          mask_next[MB_AUTH] = 1'b1;
        end
        KIND_SELF: begin
          mask_next[MB_SELF] = 1'b1;
          times_next[T_SELF] = now_t;
        end
        KIND_SYSTEM: begin
          mask_next[MB_SYSTEM] = 1'b1;
          times_next[T_SYS]    = now_t;
          opr_zero_next        = pos_zero;
        end
        KIND_OPERATOR: begin
          mask_next[MB_OPERATOR] = 1'b1;
          times_next[T_OPER]     = now_t;
        end
        default: begin
        end
      endcase
    end
  end

  // per-slot age checks; a zero stamp means never received
  always_comb begin
    for (int i = 0; i < NUM_TIMED; i++) begin
      age[i]       = now_t - times_next[i];
      stale_loc[i] = (times_next[i] == '0) || (W'(age[i]) > W'(cfg.location_max_age));
      stale_oth[i] = (times_next[i] == '0) || (W'(age[i]) > W'(cfg.other_max_age));
      fresh_sys[i] = (times_next[i] != '0) && (W'(age[i]) < W'(cfg.system_valid_age));
      fresh_loc[i] = (times_next[i] != '0) && (W'(age[i]) < W'(cfg.location_valid_age));
    end
  end

  always_comb begin
    result.good_to_arm = 1'b0;
    priority if (stale_loc[T_LOC])   result.fail_reason = RSN_NO_LOCATION;
    else if (stale_oth[T_BASIC])     result.fail_reason = RSN_NO_BASIC;
    else if (stale_oth[T_SELF])      result.fail_reason = RSN_NO_SELF;
    else if (stale_oth[T_OPER])      result.fail_reason = RSN_NO_OPERATOR;
    else if (stale_oth[T_SYS])       result.fail_reason = RSN_NO_SYSTEM;
    else if (veh_zero_next)          result.fail_reason = RSN_BAD_LOCATION;
    else if (opr_zero_next)          result.fail_reason = RSN_BAD_OPERATOR;
    else begin
      result.fail_reason = RSN_NONE;
      result.good_to_arm = 1'b1;
    end
    result.initialised = ((mask_next & MASK_REQUIRED) == MASK_REQUIRED);
    result.system_ok   = fresh_sys[T_SYS] && fresh_sys[T_SELF] &&
                         fresh_sys[T_BASIC] && fresh_sys[T_OPER];
    result.location_ok = fresh_loc[T_LOC];
  end

endmodule

FILE: rtl/core/message_freshness_arm_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_freshness_arm_check_unit
// Tracks receive times of five identification message kinds and reports an
// arm verdict, initialised flag and validity flags for every transaction.
// ----------------------------------------------------------------------------
// Usage:
//   item   : arrival (op 0) or status query (op 1) transactions, valid/ready.
//   result : one verdict transaction per item, in order, valid/ready.
//   wr_*   : register write port, one write per cycle with wr_en high;
//            write only while no item is in flight.
// An accepted item waits in the input register; when the result register is free
// or being emptied, it moves through the state update and age compares into the
// result register. Throughput is one item per cycle; item.ready stays high while
// the result register is free or being emptied in the same cycle.
// When the receiver stalls, the result holds and the input register takes
// one more item before item.ready drops.
// Synchronous reset empties both registers, clears all receive stamps and the
// received mask, marks both positions as zero and loads the default ages.
// TIME_BITS sets the width of the stored stamps and the age arithmetic.
// ----------------------------------------------------------------------------
module message_freshness_arm_check_unit
  import mfac_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  mfac_in_if.sink                 item,
  mfac_out_if.source              result,
  input  logic                    wr_en,
  input  logic [CFG_IDX_BITS-1:0] wr_index,
  input  logic [CFG_BITS-1:0]     wr_data
);

  cfg_t                                cfg;
  item_t                               in_q;
  logic                                in_full;
  result_t                             res_q;
  logic                                out_valid;
  logic [NUM_TIMED-1:0][TIME_BITS-1:0] times;
  logic [NUM_TIMED-1:0][TIME_BITS-1:0] times_next;
  logic [MASK_BITS-1:0]                mask;
  logic [MASK_BITS-1:0]                mask_next;
  logic                                veh_zero;
  logic                                veh_zero_next;
  logic                                opr_zero;
  logic                                opr_zero_next;
  result_t                             res_next;
  logic                                advance;
  item_t                               item_in;

  assign advance    = in_full && (!out_valid || result.ready);
  assign item.ready = !in_full || advance;

  assign item_in.op        = item.op;
  assign item_in.now_ms    = item.now_ms;
  assign item_in.msg_kind  = item.msg_kind;
  assign item_in.latitude  = item.latitude;
  assign item_in.longitude = item.longitude;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.location_max_age   <= LOCATION_MAX_AGE_RESET;
      cfg.other_max_age      <= OTHER_MAX_AGE_RESET;
      cfg.system_valid_age   <= SYSTEM_VALID_AGE_RESET;
      cfg.location_valid_age <= LOCATION_VALID_AGE_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LOCATION_MAX_AGE:   cfg.location_max_age   <= wr_data;
        REG_OTHER_MAX_AGE:      cfg.other_max_age      <= wr_data;
        REG_SYSTEM_VALID_AGE:   cfg.system_valid_age   <= wr_data;
        REG_LOCATION_VALID_AGE: cfg.location_valid_age <= wr_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_q <= item_in;
    end
  end

  mfac_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .item          (in_q),
    .cfg           (cfg),
    .times         (times),
    .mask          (mask),
    .veh_zero      (veh_zero),
    .opr_zero      (opr_zero),
    .times_next    (times_next),
    .mask_next     (mask_next),
    .veh_zero_next (veh_zero_next),
    .opr_zero_next (opr_zero_next),
    .result        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      times    <= '0;
      mask     <= '0;
      veh_zero <= 1'b1;
      opr_zero <= 1'b1;
    end else if (advance) begin
      times    <= times_next;
      mask     <= mask_next;
      veh_zero <= veh_zero_next;
      opr_zero <= opr_zero_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.good_to_arm = res_q.good_to_arm;
  assign result.fail_reason = res_q.fail_reason;
  assign result.initialised = res_q.initialised;
  assign result.system_ok   = res_q.system_ok;
  assign result.location_ok = res_q.location_ok;

endmodule
